FILE: hw/rtl/lstu_pkg.sv
package lstu_pkg;

  localparam int unsigned MemAddrBitsDef = 21;
  localparam int unsigned RegAddrBits    = 5;
  localparam int unsigned PcBits         = 21;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] base_new;
    logic        wb;
    logic        load;
  } agen_t;

endpackage

FILE: hw/rtl/load_store_transfer_unit.sv
// Channel | Direction | Signals                                  | Transfer
// in      | input     | instr_i, pc_i                            | in_valid_i & in_ready_o
// out     | output    | status_o, address_o, is_load_o, data_o,  | out_valid_o & out_ready_i
//         |           | base_written_o, base_value_o             |
// One instruction at a time; register file and byte memory each have one port.
// Each input reads its base and offset registers, forms the address and checks its bounds;
// a store writes n bytes and a load reads n bytes (n = 4 or 8) through the byte-wide memory
// port, one byte per cycle; a refused access goes straight to its result, then to idle.
// After reset the byte memory is cleared one byte per cycle, with in_ready_o low until
// it is done. A result waiting in the output register stalls only the final step.
module load_store_transfer_unit #(
  parameter int unsigned MEM_ADDR_BITS = lstu_pkg::MemAddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   instr_i,
  input  logic [lstu_pkg::PcBits-1:0]   pc_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [63:0]                   address_o,
  output logic                          is_load_o,
  output logic [63:0]                   data_o,
  output logic                          base_written_o,
  output logic [63:0]                   base_value_o
);

  localparam int unsigned MemDepth = 1 << MEM_ADDR_BITS;
  localparam logic [63:0] MemSize  = 64'(1) << MEM_ADDR_BITS;
  localparam int unsigned Rab      = lstu_pkg::RegAddrBits;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDRN,
    S_RDRM,
    S_ADDR,
    S_CHECK,
    S_RDRT,
    S_STORE,
    S_LOAD,
    S_LDWB,
    S_FIN
  } state_e;

  state_e                     state_q;
  logic [MEM_ADDR_BITS-1:0]   clr_q;
  logic [3:0]                 cnt_q;
  logic [31:0]                instr_q;
  logic [lstu_pkg::PcBits-1:0] pc_q;
  logic [63:0]                base_q;
  logic [63:0]                off_q;
  logic [63:0]                addr_q;
  logic [63:0]                nbase_q;
  logic                       wb_q;
  logic                       load_q;
  logic                       bad_q;
  logic [63:0]                data_q;

  logic                       out_valid_q;
  logic                       status_q;
  logic [63:0]                address_q;
  logic                       is_load_q;
  logic [63:0]                data_out_q;
  logic                       base_written_q;
  logic [63:0]                base_value_q;

  logic [63:0]                rf_mem [2**Rab];
  logic [2**Rab-1:0]          rf_vld_q;
  logic [63:0]                rf_rdata_q;
  logic                       rf_rvld_q;
  logic                       rf_re;
  logic [Rab-1:0]             rf_raddr;
  logic                       rf_we;
  logic [Rab-1:0]             rf_waddr;
  logic [63:0]                rf_wdata;
  logic [63:0]                rf_val;

  logic [7:0]                 dm_mem [MemDepth];
  logic [7:0]                 dm_rdata_q;
  logic                       dm_re;
  logic                       dm_we;
  logic [MEM_ADDR_BITS-1:0]   dm_addr;
  logic [7:0]                 dm_wdata;

  lstu_pkg::agen_t            agen;
  logic                       wide;
  logic [3:0]                 nbytes;
  logic [2:0]                 cap_idx;
  logic                       bad;

  lstu_agen u_agen (
    .instr_i (instr_q),
    .pc_i    (pc_q),
    .base_i  (base_q),
    .off_i   (off_q),
    .res_o   (agen)
  );

  assign wide    = instr_q[30];
  assign nbytes  = wide ? 4'd8 : 4'd4;
  assign cap_idx = 3'(cnt_q - 4'd1);
  assign rf_val  = rf_rvld_q ? rf_rdata_q : 64'b0;
  assign bad     = (addr_q == 64'b0) || (addr_q >= MemSize);
  assign dm_addr = (state_q == S_CLEAR) ? clr_q
                                        : addr_q[MEM_ADDR_BITS-1:0] +
                                          MEM_ADDR_BITS'(cnt_q[2:0]);

  always_comb begin
    rf_re    = 1'b0;
    rf_raddr = instr_i[9:5];
    rf_we    = 1'b0;
    rf_waddr = instr_q[4:0];
    rf_wdata = data_q;
    dm_re    = 1'b0;
    dm_we    = 1'b0;
    dm_wdata = data_q[{cnt_q[2:0], 3'b000} +: 8];
    unique case (state_q)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_wdata = 8'b0;
      end
      S_IDLE: begin
        rf_re    = in_valid_i;
        rf_raddr = instr_i[9:5];
      end
      S_RDRN: begin
        rf_re    = 1'b1;
        rf_raddr = instr_q[20:16];
      end
      S_ADDR: begin
        rf_we    = agen.wb;
        rf_waddr = instr_q[9:5];
        rf_wdata = agen.base_new;
      end
      S_CHECK: begin
        rf_re    = 1'b1;
        rf_raddr = instr_q[4:0];
      end
      S_STORE: dm_we = 1'b1;
      S_LOAD:  dm_re = (cnt_q != nbytes);
      S_LDWB:  rf_we = 1'b1;
      default: rf_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (rf_re) begin
      rf_rdata_q <= rf_mem[rf_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q  <= '0;
      rf_rvld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (rf_re) begin
        rf_rvld_q <= rf_vld_q[rf_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_addr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata_q <= dm_mem[dm_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      cnt_q          <= '0;
      instr_q        <= '0;
      pc_q           <= '0;
      base_q         <= '0;
      off_q          <= '0;
      addr_q         <= '0;
      nbase_q        <= '0;
      wb_q           <= 1'b0;
      load_q         <= 1'b0;
      bad_q          <= 1'b0;
      data_q         <= '0;
      out_valid_q    <= 1'b0;
      status_q       <= 1'b0;
      address_q      <= '0;
      is_load_q      <= 1'b0;
      data_out_q     <= '0;
      base_written_q <= 1'b0;
      base_value_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            instr_q <= instr_i;
            pc_q    <= pc_i;
            state_q <= S_RDRN;
          end
        end
        S_RDRN: begin
          base_q  <= rf_val;
          state_q <= S_RDRM;
        end
        S_RDRM: begin
          off_q   <= rf_val;
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          addr_q  <= agen.addr;
          nbase_q <= agen.base_new;
          wb_q    <= agen.wb;
          load_q  <= agen.load;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          bad_q  <= bad;
          data_q <= '0;
          cnt_q  <= '0;
          if (bad) begin
            state_q <= S_FIN;
          end else if (load_q) begin
            state_q <= S_LOAD;
          end else begin
            state_q <= S_RDRT;
          end
        end
        S_RDRT: begin
          data_q  <= wide ? rf_val : {32'b0, rf_val[31:0]};
          state_q <= S_STORE;
        end
        S_STORE: begin
          if (cnt_q == nbytes - 4'd1) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_LOAD: begin
          if (cnt_q != 4'd0) begin
            data_q[{cap_idx, 3'b000} +: 8] <= dm_rdata_q;
          end
          if (cnt_q == nbytes) begin
            state_q <= S_LDWB;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_LDWB: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            status_q       <= bad_q;
            address_q      <= addr_q;
            is_load_q      <= load_q;
            data_out_q     <= data_q;
            base_written_q <= wb_q;
            base_value_q   <= wb_q ? nbase_q : 64'b0;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign address_o      = address_q;
  assign is_load_o      = is_load_q;
  assign data_o         = data_out_q;
  assign base_written_o = base_written_q;
  assign base_value_o   = base_value_q;

endmodule

FILE: hw/rtl/lstu_agen.sv
module lstu_agen (
  input  logic [31:0]                    instr_i,
  input  logic [lstu_pkg::PcBits-1:0]    pc_i,
  input  logic [63:0]                    base_i,
  input  logic [63:0]                    off_i,
  output lstu_pkg::agen_t                res_o
);

  typedef enum logic [2:0] {
    ModeLiteral,
    ModeUnsigned,
    ModeRegister,
    ModePre,
    ModePost
  } mode_e;

  mode_e       mode;
  logic [63:0] lit;
  logic [63:0] imm_scaled;
  logic [63:0] simm9;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] sum;

  always_comb begin
    if (!instr_i[31]) begin
      mode = ModeLiteral;
    end else if (instr_i[24]) begin
      mode = ModeUnsigned;
    end else if (instr_i[21]) begin
      mode = ModeRegister;
    end else if (instr_i[11]) begin
      mode = ModePre;
    end else begin
      mode = ModePost;
    end
  end

  assign lit        = {{43{instr_i[23]}}, instr_i[23:5], 2'b00};
  assign imm_scaled = instr_i[30] ? {49'b0, instr_i[21:10], 3'b000}
                                  : {50'b0, instr_i[21:10], 2'b00};
  assign simm9      = {{55{instr_i[20]}}, instr_i[20:12]};

  always_comb begin
    op_a = base_i;
    op_b = simm9;
    unique case (mode)
      ModeLiteral: begin
        op_a = lit;
        op_b = 64'(pc_i);
      end
      ModeUnsigned: op_b = imm_scaled;
      ModeRegister: op_b = off_i;
      ModePre, ModePost: op_b = simm9;
      default: op_b = simm9;
    endcase
  end

  assign sum = op_a + op_b;

  always_comb begin
    res_o.addr     = (mode == ModePost) ? base_i : sum;
    res_o.wb       = (mode == ModePre) || (mode == ModePost);
    res_o.base_new = sum;
    res_o.load     = (mode == ModeLiteral) ? 1'b1 : instr_i[22];
  end

endmodule

FILE: dv/tb_top.sv
localparam int unsigned MemBits = lstu_pkg::MemAddrBitsDef;
localparam logic [63:0] MemSize = 64'(1) << MemBits;

typedef struct packed {
  logic        status;
  logic [63:0] address;
  logic        is_load;
  logic [63:0] data;
  logic        base_written;
  logic [63:0] base_value;
} transfer_result_t;

class transfer_scoreboard;
  logic [63:0]      regs [32];
  bit [7:0]         mem_bytes [1 << MemBits];
  transfer_result_t expected_results [$];
  int               errors;
  int               n_accepted;
  int               n_loads;
  int               n_stores;
  int               n_refused;
  int               n_writebacks;

  function new();
    foreach (regs[i]) regs[i] = '0;
    errors       = 0;
    n_accepted   = 0;
    n_loads      = 0;
    n_stores     = 0;
    n_refused    = 0;
    n_writebacks = 0;
  endfunction

  function void note_transfer(logic [31:0] instr, logic [20:0] pc);
    logic               wide;
    logic               load;
    logic               wb;
    logic               bad;
    logic [4:0]         rt;
    logic [4:0]         rn;
    logic [63:0]        addr;
    logic [63:0]        data;
    logic [63:0]        base_new;
    logic [63:0]        simm9;
    logic [63:0]        lit;
    logic [MemBits-1:0] byte_addr;
    int                 nbytes;
    transfer_result_t   res;

    wide     = instr[30];
    nbytes   = wide ? 8 : 4;
    rt       = instr[4:0];
    rn       = instr[9:5];
    load     = instr[22];
    wb       = 1'b0;
    base_new = '0;
    data     = '0;
    simm9    = {{55{instr[20]}}, instr[20:12]};

    if (instr[31]) begin
      if (instr[24]) begin
        addr = regs[rn] + (64'(instr[21:10]) << (wide ? 3 : 2));
      end else if (instr[21]) begin
        addr = regs[rn] + regs[instr[20:16]];
      end else if (instr[11]) begin
        regs[rn] = regs[rn] + simm9;
        addr     = regs[rn];
        wb       = 1'b1;
        base_new = addr;
      end else begin
        addr     = regs[rn];
        regs[rn] = regs[rn] + simm9;
        wb       = 1'b1;
        base_new = regs[rn];
      end
    end else begin
      lit  = {{43{instr[23]}}, instr[23:5], 2'b00};
      addr = lit + 64'(pc);
      load = 1'b1;
    end

    bad = (addr == '0) || (addr >= MemSize);
    if (!bad) begin
      if (load) begin
        for (int i = 0; i < nbytes; i++) begin
          byte_addr = addr[MemBits-1:0] + MemBits'(i);
          data      = data | (64'(mem_bytes[byte_addr]) << (8 * i));
        end
        regs[rt] = data;
        n_loads++;
      end else begin
        data = regs[rt];
        if (!wide) data[63:32] = '0;
        for (int i = 0; i < nbytes; i++) begin
          byte_addr            = addr[MemBits-1:0] + MemBits'(i);
          mem_bytes[byte_addr] = data[8*i +: 8];
        end
        n_stores++;
      end
    end else begin
      n_refused++;
    end
    if (wb) n_writebacks++;

    res.status       = bad;
    res.address      = addr;
    res.is_load      = load;
    res.data         = data;
    res.base_written = wb;
    res.base_value   = base_new;
    expected_results.push_back(res);
    n_accepted++;
  endfunction

  function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(transfer_result_t got);
    transfer_result_t want;
    if (expected_results.size() == 0) begin
      $error("result transfer with no instruction outstanding");
      errors++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("address", want.address, got.address);
    compare_field("is_load", 64'(want.is_load), 64'(got.is_load));
    compare_field("data", want.data, got.data);
    compare_field("base_written", 64'(want.base_written), 64'(got.base_written));
    compare_field("base_value", want.base_value, got.base_value);
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_top;

  localparam longint unsigned Limit       = 64'd10_000_000;
  localparam int unsigned     NumRandom   = 1550;
  localparam int unsigned     PauseAt     = 1100;
  localparam int unsigned     HoldOffAt   = 700;
  localparam int unsigned     HoldOffLen  = 600;
  localparam int unsigned     TailCycles  = 20;

  localparam logic Wide   = 1'b1;
  localparam logic Narrow = 1'b0;
  localparam logic Load   = 1'b1;
  localparam logic Store  = 1'b0;
  localparam logic Pre    = 1'b1;
  localparam logic Post   = 1'b0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] instr_i;
  logic [20:0] pc_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic [63:0] address_o;
  logic        is_load_o;
  logic [63:0] data_o;
  logic        base_written_o;
  logic [63:0] base_value_o;

  longint unsigned    cycle_count = 0;
  bit                 held_off    = 1'b0;
  transfer_scoreboard sb          = new();

  load_store_transfer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .instr_i        (instr_i),
    .pc_i           (pc_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .address_o      (address_o),
    .is_load_o      (is_load_o),
    .data_o         (data_o),
    .base_written_o (base_written_o),
    .base_value_o   (base_value_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > Limit) begin
      $display("load_store_transfer_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({status_o, address_o, is_load_o, data_o, base_written_o, base_value_o});
    end
  end

  function automatic logic [31:0] enc_uoff(logic wide, logic ld, logic [11:0] imm,
                                           logic [4:0] rn, logic [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b1, 1'b0, ld, imm, rn, rt};
  endfunction

  function automatic logic [31:0] enc_roff(logic wide, logic ld, logic [4:0] rm,
                                           logic [4:0] rn, logic [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b0, 1'b0, ld, 1'b1, rm, 6'b0, rn, rt};
  endfunction

  function automatic logic [31:0] enc_idx(logic wide, logic ld, logic pre, logic [8:0] simm,
                                          logic [4:0] rn, logic [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b0, 1'b0, ld, 1'b0, simm, pre, 1'b0, rn, rt};
  endfunction

  function automatic logic [31:0] enc_lit(logic wide, logic [18:0] imm, logic [4:0] rt);
    return {1'b0, wide, 6'b0, imm, rt};
  endfunction

  // bias base registers toward ones that keep the address inside memory
  function automatic void pick_instr(output logic [31:0] w, output logic [20:0] p);
    int unsigned cand [$];
    int unsigned sel;
    logic [4:0]  rn;
    logic [4:0]  rm;

    w = $urandom;
    p = 21'($urandom);
    if ($urandom_range(0, 99) < 15) return;
    foreach (sb.regs[i]) if (sb.regs[i] < MemSize) cand.push_back(i);
    if (cand.size() == 0 || $urandom_range(0, 9) == 0) begin
      w[31] = 1'b0;
      return;
    end
    rn       = 5'(cand[$urandom_range(0, cand.size() - 1)]);
    rm       = 5'(cand[$urandom_range(0, cand.size() - 1)]);
    w[31]    = 1'b1;
    w[9:5]   = rn;
    sel      = $urandom_range(0, 2);
    case (sel)
      0: begin
        w[24] = 1'b1;
        if ($urandom_range(0, 1)) w[21:10] = 12'($urandom_range(0, 63));
      end
      1: begin
        w[24]    = 1'b0;
        w[21]    = 1'b1;
        w[20:16] = rm;
      end
      default: begin
        w[24] = 1'b0;
        w[21] = 1'b0;
      end
    endcase
  endfunction

  task automatic send_item(input logic [31:0] w, input logic [20:0] p);
    in_valid_i <= 1'b1;
    instr_i    <= w;
    pc_i       <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(w, p);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_item(enc_idx(Wide, Store, Pre, 9'h1FF, 5'd1, 5'd0), 21'($urandom));
    send_item(enc_idx(Wide, Store, Pre, 9'd8, 5'd2, 5'd1), 21'($urandom));
    send_item(enc_idx(Narrow, Store, Pre, 9'd31, 5'd3, 5'd0), 21'($urandom));
    send_item(enc_uoff(Narrow, Store, 12'd4, 5'd0, 5'd3), 21'($urandom));
    send_item(enc_idx(Narrow, Load, Pre, 9'd6, 5'd2, 5'd5), 21'($urandom));
    send_item(enc_uoff(Wide, Store, 12'd0, 5'd5, 5'd1), 21'($urandom));
    send_item(enc_lit(Wide, 19'd0, 5'd9), 21'h1FFFFC);
    send_item(enc_lit(Narrow, 19'd0, 5'd9), 21'h000000);
    send_item(enc_lit(Wide, 19'h7FFFF, 5'd10), 21'h000004);
    send_item(enc_lit(Wide, 19'h40000, 5'd10), 21'h000100);
    send_item(enc_lit(Narrow, 19'h3FFFF, 5'd11), 21'h1FFFFF);
    send_item(enc_lit(Narrow, 19'd0, 5'd11), 21'h1FFFFF);
    send_item(enc_uoff(Narrow, Load, 12'd2, 5'd0, 5'd6), 21'($urandom));
    send_item(enc_uoff(Narrow, Store, 12'd10, 5'd0, 5'd1), 21'($urandom));
    send_item(enc_idx(Wide, Load, Post, 9'h100, 5'd2, 5'd7), 21'($urandom));
    send_item(enc_idx(Wide, Load, Pre, 9'd255, 5'd2, 5'd7), 21'($urandom));
    send_item(enc_idx(Wide, Load, Pre, 9'd255, 5'd4, 5'd4), 21'($urandom));
    send_item(enc_idx(Wide, Store, Pre, 9'd100, 5'd8, 5'd8), 21'($urandom));
    send_item(enc_roff(Wide, Load, 5'd1, 5'd5, 5'd12), 21'($urandom));
    send_item(enc_roff(Wide, Load, 5'd5, 5'd5, 5'd12), 21'($urandom));
    send_item(enc_uoff(Wide, Load, 12'hFFF, 5'd0, 5'd13), 21'($urandom));
    send_item(enc_idx(Narrow, Store, Pre, 9'd200, 5'd31, 5'd31), 21'($urandom));
    send_item(enc_roff(Narrow, Load, 5'd8, 5'd1, 5'd14), 21'($urandom));
    send_item(enc_idx(Wide, Store, Pre, 9'd1, 5'd5, 5'd1), 21'($urandom));
    send_item(enc_idx(Wide, Load, Post, 9'h1FF, 5'd5, 5'd15), 21'($urandom));
  endtask

  // receiver: stretches of always-ready, coin-flip, mostly-stalled and counter-pattern ready, one long hold-off
  initial begin
    int unsigned mode;
    int unsigned stretch;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(posedge clk_i);
        if (!held_off && sb.n_accepted >= HoldOffAt) begin
          held_off = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HoldOffLen) @(posedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= cycle_count[2] ^ cycle_count[4];
        endcase
      end
    end
  end

  initial begin
    logic [31:0] w;
    logic [20:0] p;
    int unsigned burst_left;
    int unsigned gap;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    instr_i     = '0;
    pc_i        = '0;
    out_ready_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    wait_drained();

    burst_left = $urandom_range(1, 40);
    for (int k = 0; k < NumRandom; k++) begin
      if (k == PauseAt) wait_drained();
      pick_instr(w, p);
      send_item(w, p);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d instructions: %0d loads and %0d stores done, %0d refused",
             sb.n_accepted, sb.n_loads, sb.n_stores, sb.n_refused);
    $display("%0d with base writeback, including a long output hold-off and a drained pause",
             sb.n_writebacks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("load_store_transfer_unit regression: pass");
    end else begin
      $display("load_store_transfer_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: load_store_transfer_unit.f
hw/rtl/lstu_pkg.sv
hw/rtl/lstu_agen.sv
hw/rtl/load_store_transfer_unit.sv
dv/tb_top.sv
